### rtl/fbfl_pkg.sv
// Shared constants and types for the fixed block free-list allocator.
package fbfl_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int CFG_W        = CNT_W;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_MEM  = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_DBLFREE = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_CHECK = 1'b1;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] nxt;
  } link_t;

endpackage

### rtl/fixed_block_free_list_allocator_core.sv
// Fixed-size block pool allocator: free list held in a link memory.
//
// Usage: one request word per item on the in channel (mode, element_index,
// no_element), one result word per item on the out channel (status,
// granted_index); both channels use valid/ready.
// Items are handled one at a time; in_ready_o is high while the sequencer is
// idle and no register write is offered, and the result sits in an output
// register so a stalled receiver does not stop the next request being taken.
// Work done from accept to result:
//   free without walk, null free, range error, empty pool: result at accept
//   allocate: one read of the link memory, then the result
//   free with double-free check: a walk of k list entries, k at most
//   element_count; each step is a link read and a compare.
// If the output register is still full when a result is ready, the result is
// parked and the sequencer waits until the receiver takes the pending word.
// Reset and an idle config write rebuild the list at once: entry i links to
// i-1 and the head is the last entry of the pool. Per-entry written flags make
// untouched entries read as the rebuilt list, so no clearing pass is needed.
module fixed_block_free_list_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [fbfl_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [fbfl_pkg::IDX_W-1:0] element_index_i,
  input  logic                       no_element_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [fbfl_pkg::IDX_W-1:0] granted_index_o
);
  import fbfl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             check_q, check_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic             head_vld_q, head_vld_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic             cur_vld_q, cur_vld_d;
  logic [CNT_W-1:0] steps_q, steps_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       res_st_q, res_st_d;
  logic [IDX_W-1:0] res_gi_q, res_gi_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_st_q, out_st_d;
  logic [IDX_W-1:0] out_gi_q, out_gi_d;

  logic [MAX_ELEMENTS-1:0] written_q, written_d;
  link_t                   mem [MAX_ELEMENTS];
  link_t                   rd_data_q;
  logic [IDX_W-1:0]        rd_addr_q;
  logic                    rd_written_q;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  link_t            wr_data, link_rd;
  logic [CNT_W-1:0] eff_n, new_count, new_n;
  logic             fin, out_free, accept;
  logic [1:0]       fin_st;
  logic [IDX_W-1:0] fin_gi;

  assign eff_n = (count_q > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : count_q;
  assign new_count = (cfg_idx_i == REG_COUNT) ? cfg_data_i : count_q;
  assign new_n = (new_count > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : new_count;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  // Untouched entries read as the rebuilt list
  always_comb begin
    if (rd_written_q) begin
      link_rd = rd_data_q;
    end else begin
      link_rd.vld = (rd_addr_q != '0) && ({1'b0, rd_addr_q} < eff_n);
      link_rd.nxt = (rd_addr_q == '0) ? '0 : rd_addr_q - IDX_W'(1);
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    check_d    = check_q;
    head_d     = head_q;
    head_vld_d = head_vld_q;
    cur_d      = cur_q;
    cur_vld_d  = cur_vld_q;
    steps_d    = steps_q;
    idx_d      = idx_q;
    res_st_d   = res_st_q;
    res_gi_d   = res_gi_q;
    written_d  = written_q;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = '{vld: head_vld_q, nxt: head_q};
    fin        = 1'b0;
    fin_st     = ST_OK;
    fin_gi     = '0;

    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          if (cfg_idx_i == REG_COUNT) begin
            count_d = cfg_data_i;
          end else begin
            check_d = cfg_data_i[0];
          end
          written_d  = '0;
          head_d     = IDX_W'(new_n - CNT_W'(1));
          head_vld_d = (new_n != '0);
        end else if (accept) begin
          idx_d = element_index_i;
          if (mode_i == MODE_ALLOC) begin
            if (!head_vld_q) begin
              fin    = 1'b1;
              fin_st = ST_NO_MEM;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q;
              state_d = S_POP;
            end
          end else if (no_element_i) begin
            fin = 1'b1;
          end else if ({1'b0, element_index_i} >= eff_n) begin
            fin    = 1'b1;
            fin_st = ST_RANGE;
          end else if (check_q) begin
            cur_d     = head_q;
            cur_vld_d = head_vld_q;
            steps_d   = '0;
            state_d   = S_CHECK;
          end else begin
            wr_en                      = 1'b1;
            wr_addr                    = element_index_i;
            written_d[element_index_i] = 1'b1;
            head_d                     = element_index_i;
            head_vld_d                 = 1'b1;
            fin                        = 1'b1;
          end
        end
      end
      S_POP: begin
        head_d     = link_rd.nxt;
        head_vld_d = link_rd.vld;
        fin        = 1'b1;
        fin_gi     = head_q;
      end
      S_CHECK: begin
        if (!cur_vld_q || steps_q == eff_n) begin
          wr_en            = 1'b1;
          wr_addr          = idx_q;
          written_d[idx_q] = 1'b1;
          head_d           = idx_q;
          head_vld_d       = 1'b1;
          fin              = 1'b1;
        end else if (cur_q == idx_q) begin
          fin    = 1'b1;
          fin_st = ST_DBLFREE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_q;
          steps_d = steps_q + CNT_W'(1);
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cur_d     = link_rd.nxt;
        cur_vld_d = link_rd.vld;
        state_d   = S_CHECK;
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      res_st_d = fin_st;
      res_gi_d = fin_gi;
      state_d  = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_gi_d    = out_gi_q;
    if (fin && out_free) begin
      out_valid_d = 1'b1;
      out_st_d    = fin_st;
      out_gi_d    = fin_gi;
    end else if (state_q == S_HOLD && out_free) begin
      out_valid_d = 1'b1;
      out_st_d    = res_st_q;
      out_gi_d    = res_gi_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CNT_W'(MAX_ELEMENTS);
      check_q     <= 1'b0;
      head_q      <= IDX_W'(MAX_ELEMENTS - 1);
      head_vld_q  <= 1'b1;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      check_q     <= check_d;
      head_q      <= head_d;
      head_vld_q  <= head_vld_d;
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    cur_vld_q <= cur_vld_d;
    steps_q   <= steps_d;
    idx_q     <= idx_d;
    res_st_q  <= res_st_d;
    res_gi_q  <= res_gi_d;
    out_st_q  <= out_st_d;
    out_gi_q  <= out_gi_d;
  end

  // Link memory with registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q    <= mem[rd_addr];
      rd_addr_q    <= rd_addr;
      rd_written_q <= written_q[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign granted_index_o = out_gi_q;

  a_head_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_vld_q |-> ({1'b0, head_q} < eff_n))
    else $error("free-list head outside pool");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (steps_q <= eff_n))
    else $error("free-list walk beyond element count");

  a_fetch_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_CHECK))
    else $error("walk fetch not followed by compare");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (granted_index_o == '0))
    else $error("granted index set on failed request");

endmodule
